### hw/rtl/dcrf_pkg.sv
// ============================================================================
// dcrf_pkg - shared types and constants for the DHCP client retry core
// Phase and action codes, configuration register map and register file type.
// ============================================================================
package dcrf_pkg;

    // Phase codes
    typedef logic [1:0] t_phase;
    localparam t_phase PH_START = 2'd0;
    localparam t_phase PH_DISC  = 2'd1;
    localparam t_phase PH_REQ   = 2'd2;
    localparam t_phase PH_DONE  = 2'd3;

    // Action codes
    typedef logic [1:0] t_action;
    localparam t_action ACT_NONE     = 2'd0;
    localparam t_action ACT_DISCOVER = 2'd1;
    localparam t_action ACT_REQUEST  = 2'd2;
    localparam t_action ACT_DONE     = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_TPS        = 3'd0;
    localparam t_cfg_idx CFG_DISC_CAP   = 3'd1;
    localparam t_cfg_idx CFG_REQ_LIMIT  = 3'd2;
    localparam t_cfg_idx CFG_OFFER_CODE = 3'd3;
    localparam t_cfg_idx CFG_ACK_CODE   = 3'd4;

    localparam int TPS_W = 11;
    localparam int SEC_W = 8;
    localparam int MSG_W = 8;
    // seconds * ticks_per_second
    localparam int PROD_W = TPS_W + SEC_W;

    typedef struct packed {
        logic [TPS_W-1:0] tps;
        logic [SEC_W-1:0] disc_cap;
        logic [SEC_W-1:0] req_limit;
        logic [MSG_W-1:0] offer_code;
        logic [MSG_W-1:0] ack_code;
    } t_cfg;

    localparam logic [TPS_W-1:0] TPS_RESET        = 11'd100;
    localparam logic [SEC_W-1:0] DISC_CAP_RESET   = 8'd60;
    localparam logic [SEC_W-1:0] REQ_LIMIT_RESET  = 8'd10;
    localparam logic [MSG_W-1:0] OFFER_CODE_RESET = 8'd2;
    localparam logic [MSG_W-1:0] ACK_CODE_RESET   = 8'd5;

endpackage

### hw/rtl/dcrf_step.sv
// ============================================================================
// dcrf_step - next-state logic of the DHCP client retry core
// Timer countdown, phase transition and interval update for one request.
// ============================================================================
module dcrf_step #(
    parameter int TIMER_WIDTH = 20
) (
    input  dcrf_pkg::t_cfg         i_cfg,
    input  dcrf_pkg::t_phase       i_phase,
    input  logic [TIMER_WIDTH-1:0] i_interval,
    input  logic [TIMER_WIDTH-1:0] i_remaining,
    input  logic                   i_command,
    input  logic [7:0]             i_msg_type,
    output dcrf_pkg::t_phase       o_phase,
    output logic [TIMER_WIDTH-1:0] o_interval,
    output logic [TIMER_WIDTH-1:0] o_remaining,
    output dcrf_pkg::t_action      o_action
);
    import dcrf_pkg::*;

    localparam int W     = TIMER_WIDTH;
    localparam int CMP_W = (W > PROD_W) ? W : PROD_W;

    logic              active;
    logic [W-1:0]      rem_dec;
    logic [W-1:0]      rem_after;
    logic              wake;
    logic [W-1:0]      tps_w;
    logic [PROD_W-1:0] cap_ticks;
    logic [PROD_W-1:0] limit_ticks;
    logic [CMP_W-1:0]  int_cmp;
    logic [W-1:0]      int_dbl;
    logic [W:0]        int_sum;
    logic [W-1:0]      int_add;

    assign active    = (i_phase == PH_DISC) || (i_phase == PH_REQ);
    assign rem_dec   = (i_remaining != '0) ? i_remaining - 1'b1 : '0;
    assign rem_after = (active && !i_command) ? rem_dec : i_remaining;
    assign wake      = active && (i_command || (rem_dec == '0));

    assign tps_w       = {{(W-TPS_W){1'b0}}, i_cfg.tps};
    assign cap_ticks   = {{TPS_W{1'b0}}, i_cfg.disc_cap} * {{SEC_W{1'b0}}, i_cfg.tps};
    assign limit_ticks = {{TPS_W{1'b0}}, i_cfg.req_limit} * {{SEC_W{1'b0}}, i_cfg.tps};
    assign int_cmp     = CMP_W'(i_interval);

    // saturating double and add
    assign int_dbl = i_interval[W-1] ? '1 : {i_interval[W-2:0], 1'b0};
    assign int_sum = {1'b0, i_interval} + {1'b0, tps_w};
    assign int_add = int_sum[W] ? '1 : int_sum[W-1:0];

    always_comb begin
        o_phase     = i_phase;
        o_interval  = i_interval;
        o_remaining = rem_after;
        o_action    = ACT_NONE;
        unique case (i_phase)
            PH_START: begin
                o_interval  = tps_w;
                o_remaining = tps_w;
                o_phase     = PH_DISC;
                o_action    = ACT_DISCOVER;
            end
            PH_DISC: begin
                if (wake) begin
                    if (i_command && (i_msg_type == i_cfg.offer_code)) begin
                        o_interval  = tps_w;
                        o_remaining = tps_w;
                        o_phase     = PH_REQ;
                        o_action    = ACT_REQUEST;
                    end else begin
                        if (int_cmp < CMP_W'(cap_ticks)) begin
                            o_interval  = int_dbl;
                            o_remaining = int_dbl;
                        end else begin
                            o_remaining = i_interval;
                        end
                        o_action = ACT_DISCOVER;
                    end
                end
            end
            PH_REQ: begin
                if (wake) begin
                    if (i_command && (i_msg_type == i_cfg.ack_code)) begin
                        o_phase  = PH_DONE;
                        o_action = ACT_DONE;
                    end else if (int_cmp <= CMP_W'(limit_ticks)) begin
                        o_interval  = int_add;
                        o_remaining = int_add;
                        o_action    = ACT_REQUEST;
                    end else begin
                        // past the limit: back to start, next request rediscovers
                        o_phase  = PH_START;
                        o_action = ACT_NONE;
                    end
                end
            end
            PH_DONE: begin
                o_action = ACT_NONE;
            end
            default: begin
                o_action = ACT_NONE;
            end
        endcase
    end

endmodule

### hw/rtl/dhcp_client_retry_fsm_core.sv
// ============================================================================
// dhcp_client_retry_fsm_core - DHCP client discover/request retransmission
// Tracks the client phase and retransmission timer; one result per request.
// ============================================================================
// Each input request is a timer tick (command 0) or a received message
// (command 1, msg_type = parsed type). Every request produces exactly one
// result: the action to take (nothing, send discover, send request,
// configured now) and the phase after the request. The core takes one
// request per clock and returns one result per clock while results are
// taken as they appear. A request is held in the input register, goes
// through the single next-state pass and is loaded with its result into
// the state/result register. The output register decouples the sides:
// while a result waits, one more request is taken into an empty input
// register, and then the input stalls until the result drains. Timer
// values are in ticks, TIMER_WIDTH bits, and saturate at all ones.
// Configuration writes (index 0..4, see dcrf_pkg) are always accepted and
// must be issued only while no request is in flight; other indexes are
// dropped. No reset sweep is needed: the core is ready right after reset.
// ============================================================================
module dhcp_client_retry_fsm_core #(
    parameter int TIMER_WIDTH = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [7:0]          i_msg_type,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dcrf_pkg::t_action   o_action,
    output dcrf_pkg::t_phase    o_phase,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  dcrf_pkg::t_cfg_idx  i_cfg_index,
    input  dcrf_pkg::t_cfg_data i_cfg_data
);
    import dcrf_pkg::*;

    // input register
    logic                   r_in_valid;
    logic                   r_command;
    logic [7:0]             r_msg_type;
    // register file
    t_cfg                   r_cfg;
    // client state
    t_phase                 r_phase;
    logic [TIMER_WIDTH-1:0] r_interval;
    logic [TIMER_WIDTH-1:0] r_remaining;
    // result register
    logic                   r_out_valid;
    t_action                r_action;
    t_phase                 r_out_phase;

    t_phase                 n_phase;
    logic [TIMER_WIDTH-1:0] n_interval;
    logic [TIMER_WIDTH-1:0] n_remaining;
    t_action                n_action;
    logic                   advance;

    // the input stage moves when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;
    assign o_phase     = r_out_phase;

    dcrf_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_phase     (r_phase),
        .i_interval  (r_interval),
        .i_remaining (r_remaining),
        .i_command   (r_command),
        .i_msg_type  (r_msg_type),
        .o_phase     (n_phase),
        .o_interval  (n_interval),
        .o_remaining (n_remaining),
        .o_action    (n_action)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command  <= i_command;
            r_msg_type <= i_msg_type;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tps        <= TPS_RESET;
            r_cfg.disc_cap   <= DISC_CAP_RESET;
            r_cfg.req_limit  <= REQ_LIMIT_RESET;
            r_cfg.offer_code <= OFFER_CODE_RESET;
            r_cfg.ack_code   <= ACK_CODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TPS:        r_cfg.tps        <= i_cfg_data;
                CFG_DISC_CAP:   r_cfg.disc_cap   <= i_cfg_data[SEC_W-1:0];
                CFG_REQ_LIMIT:  r_cfg.req_limit  <= i_cfg_data[SEC_W-1:0];
                CFG_OFFER_CODE: r_cfg.offer_code <= i_cfg_data[MSG_W-1:0];
                CFG_ACK_CODE:   r_cfg.ack_code   <= i_cfg_data[MSG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // client state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_interval  <= '0;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase     <= n_phase;
                r_interval  <= n_interval;
                r_remaining <= n_remaining;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_action    <= n_action;
            r_out_phase <= n_phase;
        end
    end

endmodule

### hw/rtl/dcrf_checker.sv
// ============================================================================
// dcrf_checker - port-level checks for the DHCP client retry core
// Result consistency and terminal phase behavior, bound to the top level.
// ============================================================================
module dcrf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input dcrf_pkg::t_action o_action,
    input dcrf_pkg::t_phase  o_phase
);
    import dcrf_pkg::*;

    // set once a configured result has been delivered
    logic r_seen_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_done <= 1'b0;
        end else if (o_out_valid && i_out_ready && (o_phase == PH_DONE)) begin
            r_seen_done <= 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_action) && $stable(o_phase))
        else $error("stalled result changed");

    // no action may go with any phase; a send names the phase it enters
    a_action_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_action == ACT_DISCOVER) && (o_phase == PH_DISC)) ||
            ((o_action == ACT_REQUEST)  && (o_phase == PH_REQ))  ||
            ((o_action == ACT_DONE)     && (o_phase == PH_DONE)) ||
            (o_action == ACT_NONE))
        else $error("action does not match phase");

    a_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_done && o_out_valid |->
            (o_phase == PH_DONE) && (o_action == ACT_NONE || !i_out_ready ||
             o_action == ACT_DONE))
        else $error("left configured phase");

endmodule

bind dhcp_client_retry_fsm_core dcrf_checker u_dcrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_action    (o_action),
    .o_phase     (o_phase)
);
